[src/circular_free_page_pool_macros.svh]
// Assertion macros used by the circular free page pool datapath
`ifndef CIRCULAR_FREE_PAGE_POOL_MACROS_SVH
`define CIRCULAR_FREE_PAGE_POOL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cfp_pkg.sv]
// Shared constants, codes and controller/datapath interface types
package cfp_pkg;

  localparam int RING_DEPTH_DEF = 4096;
  localparam int PAGE_BYTES     = 4096;
  localparam int MAX_BATCH      = 64;

  localparam int POOL_W  = 16;
  localparam int COUNT_W = 7;
  localparam int PAGE_W  = 32;
  localparam int FREE_W  = 13;

  localparam logic CFG_POOL_PAGES = 1'b0;
  localparam logic CFG_GUARD_MODE = 1'b1;

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_GRAB    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_BATCH   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef struct packed {
    logic    accept;
    logic    init_step;
    logic    init_done;
    logic    grab_load;
    logic    pop;
    logic    batch_upd;
    logic    mod_start;
    logic    mod_step;
    logic    push;
    logic    emit;
    status_t emit_status;
    logic    emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  cap_zero;
    logic  free_zero;
    logic  full;
    logic  grab_zero;
    logic  batch_zero;
    logic  drop_eff;
    logic  init_last;
    logic  grab_last;
    logic  mod_done;
  } dp_stat_t;

endpackage

[src/circular_free_page_pool.sv]
// Top level of the circular free page pool: controller plus datapath
//
//   Port group | Handshake              | Payload
//   -----------+------------------------+---------------------------------------------
//   in_        | start & !busy          | in_mode, in_count, in_page, in_batch_first
//   out_       | out_strobe, one cycle  | out_page_out, out_status, out_last,
//              |                        | out_free_count
//   cfg_       | cfg_we                 | cfg_index, cfg_wdata
//
// Init writes the ring one entry a cycle.
// Grab reads the ring one page a cycle; each page appears in the cycle after its read.
// Release computes the tail index in the bit-serial tail modulo unit.
// Reject and status-only transactions emit a single result; each result lies on the ports 1 cycle.
// Reset is synchronous on rst_n low; the ring needs no clearing pass.
// The receiver cannot stall: results are never held.
module circular_free_page_pool
  import cfp_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [POOL_W-1:0]  cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [COUNT_W-1:0] in_count,
  input  logic [PAGE_W-1:0]  in_page,
  input  logic               in_batch_first,
  output logic               out_strobe,
  output logic [PAGE_W-1:0]  out_page_out,
  output logic [1:0]         out_status,
  output logic               out_last,
  output logic [FREE_W-1:0]  out_free_count
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  cfp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  cfp_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_mode        (in_mode),
    .in_count       (in_count),
    .in_page        (in_page),
    .in_batch_first (in_batch_first),
    .cmd            (cmd),
    .stat           (stat),
    .out_strobe     (out_strobe),
    .out_page_out   (out_page_out),
    .out_status     (out_status),
    .out_last       (out_last),
    .out_free_count (out_free_count)
  );

endmodule

[src/cfp_ram.sv]
// Generic simple dual-port RAM with registered read data
module cfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/cfp_ctrl.sv]
// Controller state machine sequencing init, grab, release and batch transactions
module cfp_ctrl
  import cfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INIT,
    S_GRAB,
    S_MOD
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd             = '0;
    cmd.emit_status = ST_OK;
    cmd.emit_last   = 1'b1;
    state_nxt       = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.mode)
          MODE_INIT: begin
            if (stat.cap_zero) begin
              cmd.init_done = 1'b1;
              cmd.emit      = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_INIT;
            end
          end
          MODE_GRAB: begin
            if (stat.free_zero || stat.cap_zero) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_EMPTY;
              state_nxt       = S_IDLE;
            end else if (stat.grab_zero) begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              cmd.grab_load = 1'b1;
              state_nxt     = S_GRAB;
            end
          end
          MODE_RELEASE: begin
            if (stat.full) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_REJECT;
              state_nxt       = S_IDLE;
            end else begin
              cmd.mod_start = 1'b1;
              state_nxt     = S_MOD;
            end
          end
          MODE_BATCH: begin
            cmd.batch_upd = 1'b1;
            if (stat.batch_zero) begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
            end else if (stat.drop_eff || stat.full) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_REJECT;
              state_nxt       = S_IDLE;
            end else begin
              cmd.mod_start = 1'b1;
              state_nxt     = S_MOD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.init_last) begin
          cmd.init_done = 1'b1;
          cmd.emit      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_GRAB: begin
        cmd.pop       = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_last = stat.grab_last;
        if (stat.grab_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_MOD: begin
        if (stat.mod_done) begin
          cmd.push  = 1'b1;
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

[src/cfp_dp.sv]
// Datapath: configuration, ring pointers, batch state, tail modulo unit and page ring
`include "circular_free_page_pool_macros.svh"
module cfp_dp
  import cfp_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [POOL_W-1:0]  cfg_wdata,
  input  logic [1:0]         in_mode,
  input  logic [COUNT_W-1:0] in_count,
  input  logic [PAGE_W-1:0]  in_page,
  input  logic               in_batch_first,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat,
  output logic               out_strobe,
  output logic [PAGE_W-1:0]  out_page_out,
  output logic [1:0]         out_status,
  output logic               out_last,
  output logic [FREE_W-1:0]  out_free_count
);

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int CW  = $clog2(RING_DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int MCW = $clog2(SW + 1);

  logic [POOL_W-1:0]  pool_pages_r;
  logic               guard_mode_r;

  logic [1:0]         item_mode_r;
  logic [COUNT_W-1:0] item_cnt_r;
  logic [PAGE_W-1:0]  item_page_r;
  logic               item_first_r;
  logic [CW-1:0]      cap_r;
  logic [POOL_W-1:0]  reserved_r;

  logic [CW-1:0]      head_r;
  logic [CW-1:0]      free_r;
  logic               dropping_r;
  logic [COUNT_W-1:0] batch_left_r;
  logic [COUNT_W-1:0] grab_left_r;
  logic [CW-1:0]      init_idx_r;

  logic [SW-1:0]      mod_num_r;
  logic [SW-1:0]      mod_rem_r;
  logic [MCW-1:0]     mod_cnt_r;

  logic               out_strobe_r;
  status_t            out_status_r;
  logic               out_last_r;
  logic               out_grab_r;

  logic [POOL_W+2:0]  res_sum;
  logic [POOL_W-1:0]  reserved;
  logic [POOL_W-1:0]  avail;
  logic [POOL_W-1:0]  avail_g;
  logic [CW-1:0]      cap_calc;
  logic [COUNT_W-1:0] cnt_c;
  logic [COUNT_W-1:0] grab_n;
  logic [COUNT_W-1:0] bl_eff;
  logic               drop_eff;
  logic [CW-1:0]      head_w;
  logic [PAGE_W-1:0]  init_data;
  logic [SW-1:0]      mod_shift;
  logic [SW-1:0]      mod_rem_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [PAGE_W-1:0]  ram_wdata;
  logic [PAGE_W-1:0]  ram_rdata;

  always_comb begin
    res_sum  = {1'b0, pool_pages_r, 2'b00} + (POOL_W + 3)'(PAGE_BYTES - 1);
    reserved = POOL_W'(res_sum / PAGE_BYTES);
    avail    = (pool_pages_r > reserved) ? pool_pages_r - reserved : '0;
    avail_g  = guard_mode_r ? (avail >> 1) : avail;
    cap_calc = (32'(avail_g) > 32'(RING_DEPTH)) ? CW'(RING_DEPTH) : CW'(avail_g);

    cnt_c    = (item_cnt_r > COUNT_W'(MAX_BATCH)) ? COUNT_W'(MAX_BATCH) : item_cnt_r;
    grab_n   = (32'(cnt_c) > 32'(free_r)) ? COUNT_W'(free_r) : cnt_c;
    bl_eff   = item_first_r ? cnt_c : batch_left_r;
    drop_eff = item_first_r ? ((32'(free_r) + 32'(cnt_c)) > 32'(cap_r)) : dropping_r;

    head_w    = (head_r >= cap_r) ? '0 : head_r;
    init_data = 32'(reserved_r)
              + (guard_mode_r ? (32'(init_idx_r) << 1) : 32'(init_idx_r));

    mod_shift   = {mod_rem_r[SW-2:0], mod_num_r[SW-1]};
    mod_rem_nxt = (mod_shift >= SW'(cap_r)) ? mod_shift - SW'(cap_r) : mod_shift;
  end

  always_comb begin
    stat.mode       = mode_t'(item_mode_r);
    stat.cap_zero   = (cap_r == '0);
    stat.free_zero  = (free_r == '0);
    stat.full       = (free_r >= cap_r);
    stat.grab_zero  = (cnt_c == '0);
    stat.batch_zero = (bl_eff == '0);
    stat.drop_eff   = drop_eff;
    stat.init_last  = (init_idx_r == cap_r - 1'b1);
    stat.grab_last  = (grab_left_r == COUNT_W'(1));
    stat.mod_done   = (mod_cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_pages_r <= '0;
      guard_mode_r <= 1'b0;
      head_r       <= '0;
      free_r       <= '0;
      dropping_r   <= 1'b0;
      batch_left_r <= '0;
      grab_left_r  <= '0;
      init_idx_r   <= '0;
      mod_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POOL_PAGES: pool_pages_r <= cfg_wdata;
          CFG_GUARD_MODE: guard_mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        init_idx_r <= '0;
      end
      if (cmd.init_step) begin
        init_idx_r <= init_idx_r + 1'b1;
      end
      if (cmd.init_done) begin
        head_r       <= '0;
        free_r       <= cap_r;
        dropping_r   <= 1'b0;
        batch_left_r <= '0;
      end
      if (cmd.grab_load) begin
        grab_left_r <= grab_n;
      end
      if (cmd.pop) begin
        head_r      <= head_w + 1'b1;
        free_r      <= free_r - 1'b1;
        grab_left_r <= grab_left_r - 1'b1;
      end
      if (cmd.batch_upd) begin
        dropping_r   <= drop_eff;
        batch_left_r <= (bl_eff == '0) ? '0 : bl_eff - 1'b1;
      end
      if (cmd.mod_start) begin
        mod_cnt_r <= MCW'(SW);
      end
      if (cmd.mod_step) begin
        mod_cnt_r <= mod_cnt_r - 1'b1;
      end
      if (cmd.push) begin
        free_r <= free_r + 1'b1;
      end
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_mode_r  <= in_mode;
      item_cnt_r   <= in_count;
      item_page_r  <= in_page;
      item_first_r <= in_batch_first;
      cap_r        <= cap_calc;
      reserved_r   <= reserved;
    end
    if (cmd.mod_start) begin
      mod_num_r <= SW'(head_r) + SW'(free_r);
      mod_rem_r <= '0;
    end
    if (cmd.mod_step) begin
      mod_num_r <= mod_num_r << 1;
      mod_rem_r <= mod_rem_nxt;
    end
    out_status_r <= cmd.emit_status;
    out_last_r   <= cmd.emit_last;
    out_grab_r   <= cmd.pop;
  end

  assign ram_we    = cmd.init_step | cmd.push;
  assign ram_waddr = cmd.push ? AW'(mod_rem_r) : AW'(init_idx_r);
  assign ram_wdata = cmd.push ? item_page_r : init_data;

  cfp_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.pop),
    .raddr (AW'(head_w)),
    .rdata (ram_rdata)
  );

  assign out_strobe     = out_strobe_r;
  assign out_page_out   = out_grab_r ? ram_rdata : '0;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;
  assign out_free_count = FREE_W'(free_r);

  `CFP_ASSERT_NOW(a_pop_not_empty, cmd.pop, free_r != '0, "pop from an empty ring")
  `CFP_ASSERT_NOW(a_push_has_room, cmd.push, free_r < cap_r, "push into a full ring")
  `CFP_ASSERT_NEXT(a_push_counts, cmd.push, free_r == $past(free_r) + 1'b1,
    "free count not advanced by push")
  `CFP_ASSERT_NOW(a_tail_in_range, cmd.push, mod_rem_r < SW'(cap_r),
    "tail index beyond capacity")

endmodule

[sim/tb_circular_free_page_pool.sv]
// Self-checking testbench for the circular free page pool: directed corner cases, then random traffic
`timescale 1ns / 1ps

module tb_circular_free_page_pool;
  import cfp_pkg::*;

  typedef struct {
    logic [PAGE_W-1:0] page;
    status_t           status;
    logic              last;
    logic [FREE_W-1:0] free;
  } reply_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               cfg_we         = 1'b0;
  logic               cfg_index      = CFG_POOL_PAGES;
  logic [POOL_W-1:0]  cfg_wdata      = '0;
  logic               start          = 1'b0;
  logic [1:0]         in_mode        = MODE_INIT;
  logic [COUNT_W-1:0] in_count       = '0;
  logic [PAGE_W-1:0]  in_page        = '0;
  logic               in_batch_first = 1'b0;
  logic               busy;
  logic               out_strobe;
  logic [PAGE_W-1:0]  out_page_out;
  logic [1:0]         out_status;
  logic               out_last;
  logic [FREE_W-1:0]  out_free_count;

  logic [PAGE_W-1:0] pool_ring [RING_DEPTH_DEF];
  int unsigned       pool_head   = 0;
  int unsigned       pool_free   = 0;
  int unsigned       batch_left  = 0;
  bit                batch_drop  = 1'b0;
  int unsigned       cfg_pages   = 0;
  bit                cfg_guard   = 1'b0;
  reply_t            due_replies [$];
  int unsigned       errors      = 0;
  int unsigned       burst_left  = 0;
  int unsigned       items_sent  = 0;

  circular_free_page_pool u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_count      (in_count),
    .in_page       (in_page),
    .in_batch_first(in_batch_first),
    .out_strobe    (out_strobe),
    .out_page_out  (out_page_out),
    .out_status    (out_status),
    .out_last      (out_last),
    .out_free_count(out_free_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_circular_free_page_pool NOT OK");
    $finish;
  end

  function automatic int unsigned ring_pages();
    return (cfg_pages * 4 + PAGE_BYTES - 1) / PAGE_BYTES;
  endfunction

  function automatic int unsigned usable_pages();
    int unsigned r;
    int unsigned c;
    r = ring_pages();
    c = (cfg_pages > r) ? cfg_pages - r : 0;
    if (cfg_guard) c = c / 2;
    if (c > RING_DEPTH_DEF) c = RING_DEPTH_DEF;
    return c;
  endfunction

  function automatic void owe(logic [PAGE_W-1:0] page, status_t st, logic last);
    reply_t r;
    r.page   = page;
    r.status = st;
    r.last   = last;
    r.free   = pool_free[FREE_W-1:0];
    due_replies = {due_replies, r};
  endfunction

  function automatic bit ring_push(int unsigned cap, logic [PAGE_W-1:0] pg);
    if (pool_free >= cap) return 1'b0;
    pool_ring[(pool_head + pool_free) % cap] = pg;
    pool_free++;
    return 1'b1;
  endfunction

  function automatic void predict_pool(mode_t md, logic [COUNT_W-1:0] cnt,
                                       logic [PAGE_W-1:0] pg, bit first);
    int unsigned cap;
    int unsigned base;
    int unsigned n;
    int unsigned i;
    logic [PAGE_W-1:0] v;
    cap  = usable_pages();
    base = ring_pages();
    case (md)
      MODE_INIT: begin
        for (i = 0; i < cap; i++) pool_ring[i] = cfg_guard ? base + 2 * i : base + i;
        pool_head  = 0;
        pool_free  = cap;
        batch_drop = 1'b0;
        batch_left = 0;
        owe('0, ST_OK, 1'b1);
      end
      MODE_GRAB: begin
        if (pool_free == 0 || cap == 0) begin
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          n = (cnt > MAX_BATCH) ? MAX_BATCH : cnt;
          if (n > pool_free) n = pool_free;
          if (n == 0) owe('0, ST_OK, 1'b1);
          for (i = 0; i < n; i++) begin
            if (pool_head >= cap) pool_head = 0;
            v = pool_ring[pool_head];
            pool_head++;
            pool_free--;
            owe(v, ST_OK, i + 1 == n);
          end
        end
      end
      MODE_RELEASE: begin
        owe('0, ring_push(cap, pg) ? ST_OK : ST_REJECT, 1'b1);
      end
      default: begin
        if (first) begin
          batch_left = (cnt > MAX_BATCH) ? MAX_BATCH : cnt;
          batch_drop = (pool_free + batch_left > cap);
        end
        if (batch_left == 0) begin
          owe('0, ST_OK, 1'b1);
        end else begin
          batch_left--;
          if (batch_drop) owe('0, ST_REJECT, 1'b1);
          else owe('0, ring_push(cap, pg) ? ST_OK : ST_REJECT, 1'b1);
        end
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_strobe) begin
      if (due_replies.size() == 0) begin
        flag_mismatch($sformatf("result with nothing due: page %0h status %0d",
                                out_page_out, out_status));
      end else begin
        want = due_replies.pop_front();
        if (out_page_out !== want.page)
          flag_mismatch($sformatf("page %0h, want %0h", out_page_out, want.page));
        if (out_status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_last !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
        if (out_free_count !== want.free)
          flag_mismatch($sformatf("free count %0d, want %0d", out_free_count, want.free));
      end
    end
  end

  task automatic send_op(mode_t md, logic [COUNT_W-1:0] cnt, logic [PAGE_W-1:0] pg,
                         bit first);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start          <= 1'b1;
    in_mode        <= md;
    in_count       <= cnt;
    in_page        <= pg;
    in_batch_first <= first;
    do @(posedge clk); while (busy);
    predict_pool(md, cnt, pg, first);
    items_sent++;
  endtask

  // hold off until every transaction has completed, then let the block settle
  task automatic drain_pool();
    start <= 1'b0;
    @(posedge clk);
    while (due_replies.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_pool(int unsigned pages, bit guard);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POOL_PAGES;
    cfg_wdata <= pages[POOL_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_GUARD_MODE;
    cfg_wdata <= POOL_W'(guard);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_pages = pages & 16'hFFFF;
    cfg_guard = guard;
  endtask

  task automatic test_unconfigured();
    send_op(MODE_GRAB, 7'd1, 32'h0, 1'b0);
    send_op(MODE_RELEASE, 7'd1, 32'h0000_0042, 1'b0);
    send_op(MODE_BATCH, 7'd2, 32'h0000_0043, 1'b1);
    send_op(MODE_INIT, 7'd0, 32'h0, 1'b0);
    drain_pool();
  endtask

  task automatic test_small_ring();
    set_pool(10, 1'b0);
    send_op(MODE_INIT, 7'd1, 32'h0, 1'b0);
    send_op(MODE_GRAB, 7'd0, 32'hFFFF_FFFF, 1'b1);
    send_op(MODE_GRAB, 7'd1, 32'h0, 1'b0);
    send_op(MODE_GRAB, 7'd127, 32'h0, 1'b0);
    send_op(MODE_GRAB, 7'd1, 32'h0, 1'b0);
    send_op(MODE_RELEASE, 7'd1, 32'hFFFF_FFFF, 1'b0);
    send_op(MODE_RELEASE, 7'd64, 32'h0, 1'b1);
    send_op(MODE_GRAB, 7'd2, 32'h0, 1'b0);
    send_op(MODE_BATCH, 7'd3, 32'hAAAA_5555, 1'b1);
    send_op(MODE_BATCH, 7'd127, 32'h5555_AAAA, 1'b0);
    send_op(MODE_BATCH, 7'd0, 32'h0000_1234, 1'b0);
    send_op(MODE_BATCH, 7'd5, 32'h0000_4321, 1'b0);
    send_op(MODE_BATCH, 7'd0, 32'h0000_0001, 1'b1);
    send_op(MODE_BATCH, 7'd127, 32'h0000_0002, 1'b1);
    send_op(MODE_BATCH, 7'd0, 32'h0000_0003, 1'b0);
    send_op(MODE_INIT, 7'd0, 32'h0, 1'b0);
    send_op(MODE_RELEASE, 7'd1, 32'h0000_0100, 1'b0);
    send_op(MODE_GRAB, 7'd2, 32'h0, 1'b0);
    send_op(MODE_BATCH, 7'd2, 32'h0000_0200, 1'b1);
    send_op(MODE_RELEASE, 7'd1, 32'h0000_0300, 1'b0);
    send_op(MODE_BATCH, 7'd1, 32'h0000_0400, 1'b0);
    drain_pool();
  endtask

  task automatic test_guard_pages();
    set_pool(20, 1'b1);
    send_op(MODE_INIT, 7'd0, 32'h0, 1'b0);
    send_op(MODE_GRAB, 7'd64, 32'h0, 1'b0);
    send_op(MODE_RELEASE, 7'd1, 32'h0000_0007, 1'b0);
    send_op(MODE_GRAB, 7'd3, 32'h0, 1'b0);
    drain_pool();
  endtask

  task automatic test_full_ring();
    set_pool(16'hFFFF, 1'b1);
    send_op(MODE_INIT, 7'd0, 32'h0, 1'b0);
    send_op(MODE_RELEASE, 7'd1, 32'h8000_0001, 1'b0);
    send_op(MODE_GRAB, 7'd64, 32'h0, 1'b0);
    send_op(MODE_RELEASE, 7'd1, 32'h8000_0002, 1'b0);
    send_op(MODE_GRAB, 7'd64, 32'h0, 1'b0);
    drain_pool();
  endtask

  task automatic random_op();
    int unsigned r;
    int unsigned k;
    int unsigned j;
    logic [COUNT_W-1:0] cnt;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      cnt = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 127))
                                        : COUNT_W'($urandom_range(1, 8));
      send_op(MODE_GRAB, cnt, $urandom, 1'($urandom_range(0, 1)));
    end else if (r < 60) begin
      send_op(MODE_RELEASE, COUNT_W'($urandom_range(0, 127)), $urandom,
              1'($urandom_range(0, 1)));
    end else if (r < 90) begin
      cnt = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(0, 127))
                                        : COUNT_W'($urandom_range(1, 6));
      k = (cnt > MAX_BATCH) ? MAX_BATCH : cnt;
      k = k + $urandom_range(0, 1);
      send_op(MODE_BATCH, cnt, $urandom, 1'b1);
      for (j = 1; j < k; j++) begin
        if ($urandom_range(0, 15) == 0) break;
        if ($urandom_range(0, 9) == 0)
          send_op(MODE_RELEASE, COUNT_W'($urandom_range(0, 127)), $urandom, 1'b0);
        send_op(MODE_BATCH, COUNT_W'($urandom_range(0, 127)), $urandom, 1'b0);
      end
    end else if (r < 96) begin
      send_op(MODE_BATCH, COUNT_W'($urandom_range(0, 127)), $urandom, 1'b0);
    end else begin
      send_op(MODE_INIT, COUNT_W'($urandom_range(0, 127)), $urandom,
              1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned pages;
    int unsigned target;
    for (phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 7))
        0:       pages = 0;
        1:       pages = 1;
        2:       pages = 16'hFFFF;
        3:       pages = 4160;
        default: pages = $urandom_range(2, 60);
      endcase
      set_pool(pages, 1'($urandom_range(0, 1)));
      send_op(MODE_INIT, COUNT_W'($urandom_range(0, 127)), $urandom,
              1'($urandom_range(0, 1)));
      target = items_sent + 32;
      while (items_sent < target) random_op();
      drain_pool();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unconfigured();
    test_small_ring();
    test_guard_pages();
    test_full_ring();
    test_random_traffic();
    drain_pool();
    if (errors == 0) begin
      $display("tb_circular_free_page_pool OK");
    end else begin
      $display("tb_circular_free_page_pool NOT OK");
    end
    $finish;
  end

endmodule
